// ----- hw/rtl/idq_pkg.sv -----
// Shared types and codes for the indexed deque buffer.
package idq_pkg;

   localparam int VALUE_W  = 32;
   localparam int TARGET_W = 8;

   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_INSERT     = 3'd4;
   localparam logic [2:0] REQ_REMOVE     = 3'd5;
   localparam logic [2:0] REQ_FIND       = 3'd6;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [2:0] CELL_HOLD  = 3'd0;
   localparam logic [2:0] CELL_INS   = 3'd1;
   localparam logic [2:0] CELL_DROP  = 3'd2;
   localparam logic [2:0] CELL_CAPT  = 3'd3;
   localparam logic [2:0] CELL_SHIFT = 3'd4;

   typedef struct packed {
      logic [2:0]                req_type;
      logic [4:0]                position;
      logic signed [VALUE_W-1:0] item_value;
   } idq_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [3:0] found_index;
      logic [4:0] entry_count;
   } idq_rsp_type;

   typedef struct packed {
      logic [2:0]          op;
      logic [TARGET_W-1:0] target;
      logic [VALUE_W-1:0]  key;
   } idq_cmd_type;

endpackage

// ----- hw/rtl/idq_cell.sv -----
// One storage cell of the deque chain: holds a value and a match flag.
module idq_cell
   import idq_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  idq_cmd_type        cmd,
   input  logic [VALUE_W-1:0] left_value,
   input  logic [VALUE_W-1:0] right_value,
   input  logic               right_match,
   output logic [VALUE_W-1:0] value,
   output logic               match
);

   localparam logic [TARGET_W-1:0] MY_INDEX = TARGET_W'(INDEX);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               match_ff;
   logic               match_in;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (cmd.op)
         CELL_INS: begin
            if (MY_INDEX == cmd.target) begin
               value_in = cmd.key;
            end else if (MY_INDEX > cmd.target) begin
               value_in = left_value;
            end
         end
         CELL_DROP: begin
            if (MY_INDEX >= cmd.target) begin
               value_in = right_value;
            end
         end
         CELL_CAPT: begin
            match_in = (value_ff == cmd.key);
         end
         CELL_SHIFT: begin
            match_in = right_match;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

// ----- hw/rtl/indexed_deque_buffer.sv -----
// Top level of the indexed deque buffer: request decode, count, search scan and result buffer.
// A row of CAPACITY cells holds the ordered values, position 0 in cell 0. Push, pop, insert and
// remove move every affected value one cell at once, and the next request can be accepted in the
// following cycle unless the output buffer is full. A find compares all cells at once, then
// shifts the match flags toward cell 0 one cell per cycle until the first match or the end of
// the stored values; no request is accepted until the scan is over. Results go through a
// two-entry output buffer, so requests keep being accepted while up to one earlier result
// waits to be taken.
module indexed_deque_buffer
   import idq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  idq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output idq_rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 5) ? CW : 5;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic [VALUE_W-1:0] value_w [CAPACITY];
   logic               match_w [CAPACITY];
   idq_cmd_type        cmd;

   logic          state_ff;
   logic          state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_in;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   idq_rsp_type rsp_data_ff;
   idq_rsp_type rsp_data_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   idq_rsp_type skid_data_ff;
   idq_rsp_type skid_data_in;

   logic        accept;
   logic        pop;
   logic        res_fire;
   idq_rsp_type res;
   logic        full;
   logic        empty;
   logic [2:0]  op;
   logic [1:0]  status;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [VALUE_W-1:0] left_v;
         logic [VALUE_W-1:0] right_v;
         logic               right_m;
         if (gi == 0) begin : g_first
            assign left_v = '0;
         end else begin : g_mid_l
            assign left_v = value_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_v = '0;
            assign right_m = 1'b0;
         end else begin : g_mid_r
            assign right_v = value_w[gi+1];
            assign right_m = match_w[gi+1];
         end
         idq_cell #(
            .INDEX (gi)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_value  (left_v),
            .right_value (right_v),
            .right_match (right_m),
            .value       (value_w[gi]),
            .match       (match_w[gi])
         );
      end
   endgenerate

   assign req_ready = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid_ff && rsp_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      op         = CELL_HOLD;
      status     = STATUS_DONE;
      cmd.target = '0;
      cmd.key    = req_data.item_value;
      count_in   = count_ff;
      state_in   = state_ff;
      idx_in     = idx_ff;
      res_fire   = 1'b0;
      res.status      = STATUS_DONE;
      res.found       = 1'b0;
      res.found_index = '0;
      res.entry_count = 5'(count_ff);
      if (state_ff == ST_SCAN) begin
         op = CELL_SHIFT;
         if (idx_ff >= count_ff) begin
            res_fire = 1'b1;
            state_in = ST_IDLE;
         end else if (match_w[0]) begin
            res_fire        = 1'b1;
            res.found       = 1'b1;
            res.found_index = 4'(idx_ff);
            state_in        = ST_IDLE;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (accept) begin
         res_fire = 1'b1;
         case (req_data.req_type)
            REQ_PUSH_FRONT: begin
               if (full) begin
                  status = STATUS_FULL;
               end else begin
                  op       = CELL_INS;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_PUSH_BACK: begin
               if (full) begin
                  status = STATUS_FULL;
               end else begin
                  op         = CELL_INS;
                  cmd.target = TARGET_W'(count_ff);
                  count_in   = count_ff + 1'b1;
               end
            end
            REQ_POP_FRONT: begin
               if (empty) begin
                  status = STATUS_BAD;
               end else begin
                  op       = CELL_DROP;
                  count_in = count_ff - 1'b1;
               end
            end
            REQ_POP_BACK: begin
               if (empty) begin
                  status = STATUS_BAD;
               end else begin
                  op         = CELL_DROP;
                  cmd.target = TARGET_W'(count_ff - 1'b1);
                  count_in   = count_ff - 1'b1;
               end
            end
            REQ_INSERT: begin
               if (PW'(req_data.position) > PW'(count_ff)) begin
                  status = STATUS_BAD;
               end else if (full) begin
                  status = STATUS_FULL;
               end else begin
                  op         = CELL_INS;
                  cmd.target = TARGET_W'(req_data.position);
                  count_in   = count_ff + 1'b1;
               end
            end
            REQ_REMOVE: begin
               if (PW'(req_data.position) >= PW'(count_ff)) begin
                  status = STATUS_BAD;
               end else begin
                  op         = CELL_DROP;
                  cmd.target = TARGET_W'(req_data.position);
                  count_in   = count_ff - 1'b1;
               end
            end
            REQ_FIND: begin
               op       = CELL_CAPT;
               res_fire = 1'b0;
               state_in = ST_SCAN;
               idx_in   = '0;
            end
            default: begin
               status = STATUS_BAD;
            end
         endcase
         res.status      = status;
         res.entry_count = 5'(count_in);
      end
      cmd.op = op;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         rsp_valid_in  = skid_valid_ff || res_fire;
         rsp_data_in   = skid_valid_ff ? skid_data_ff : res;
         skid_valid_in = skid_valid_ff && res_fire;
         skid_data_in  = res;
      end else if (res_fire) begin
         if (rsp_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("stored count exceeds capacity");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("buffered result without a result at the output");

   a_find_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.req_type == REQ_FIND)) |=> (state_ff == ST_SCAN))
      else $error("find request did not start a scan");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.found) |-> (rsp_data_ff.status == STATUS_DONE))
      else $error("match reported with an error status");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the indexed deque buffer with a shadow model of the stored sequence.
`timescale 1ns / 100ps

module tb_top;
   import idq_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 1450;
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   idq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   idq_rsp_type rsp_data;

   idq_req_type queued_requests[$];
   idq_rsp_type awaited_results[$];

   logic signed [VALUE_W-1:0] stored_values [CAPACITY];
   int stored_count = 0;
   int plan_count = 0;

   int  accepted_items = 0;
   int  error_count = 0;
   int  send_idle_pct = 30;
   int  recv_idle_pct = 77;
   bit  req_taken = 1'b0;
   bit  pressure_done = 1'b0;
   int  hold_left = 0;

   logic signed [VALUE_W-1:0] value_pool [6] = '{32'sh0000_0001, 32'shFFFF_FFFE,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0007, 32'sh8000_0001};

   indexed_deque_buffer #(.CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void shift_in(int pos, logic signed [VALUE_W-1:0] val);
      for (int i = stored_count; i > pos; i--) begin
         stored_values[i] = stored_values[i-1];
      end
      stored_values[pos] = val;
      stored_count++;
   endfunction

   function automatic void shift_out(int pos);
      for (int i = pos; i + 1 < stored_count; i++) begin
         stored_values[i] = stored_values[i+1];
      end
      stored_count--;
   endfunction

   function automatic idq_rsp_type deque_response(idq_req_type rq);
      idq_rsp_type rs;
      int pos;
      rs = '0;
      rs.status = STATUS_DONE;
      pos = rq.position;
      case (rq.req_type)
         REQ_PUSH_FRONT: begin
            if (stored_count >= CAPACITY) rs.status = STATUS_FULL;
            else shift_in(0, rq.item_value);
         end
         REQ_PUSH_BACK: begin
            if (stored_count >= CAPACITY) rs.status = STATUS_FULL;
            else shift_in(stored_count, rq.item_value);
         end
         REQ_POP_FRONT: begin
            if (stored_count == 0) rs.status = STATUS_BAD;
            else shift_out(0);
         end
         REQ_POP_BACK: begin
            if (stored_count == 0) rs.status = STATUS_BAD;
            else shift_out(stored_count - 1);
         end
         REQ_INSERT: begin
            if (pos > stored_count) rs.status = STATUS_BAD;
            else if (stored_count >= CAPACITY) rs.status = STATUS_FULL;
            else shift_in(pos, rq.item_value);
         end
         REQ_REMOVE: begin
            if (pos >= stored_count) rs.status = STATUS_BAD;
            else shift_out(pos);
         end
         REQ_FIND: begin
            for (int i = 0; i < stored_count; i++) begin
               if (!rs.found && stored_values[i] == rq.item_value) begin
                  rs.found = 1'b1;
                  rs.found_index = i[3:0];
               end
            end
         end
         default: begin
            rs.status = STATUS_BAD;
         end
      endcase
      rs.entry_count = stored_count[4:0];
      return rs;
   endfunction

   // The generator keeps only the count so that indexes can be aimed at the live range.
   task automatic add_item(logic [2:0] kind, int pos, logic signed [VALUE_W-1:0] val);
      idq_req_type rq;
      rq.req_type = kind;
      rq.position = pos[4:0];
      rq.item_value = val;
      queued_requests.push_back(rq);
      case (kind)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: if (plan_count < CAPACITY) plan_count++;
         REQ_POP_FRONT, REQ_POP_BACK: if (plan_count > 0) plan_count--;
         REQ_INSERT: if (pos[4:0] <= plan_count && plan_count < CAPACITY) plan_count++;
         REQ_REMOVE: if (pos[4:0] < plan_count) plan_count--;
         default: ;
      endcase
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 40) return value_pool[$urandom_range(5)];
      if (r < 45) return 32'sh8000_0000;
      if (r < 50) return 32'sh7FFF_FFFF;
      if (r < 53) return 32'sh0;
      if (r < 56) return -32'sh1;
      return $urandom;
   endfunction

   function automatic int pick_position(bit for_remove);
      int r;
      r = $urandom_range(99);
      if (r < 85) begin
         if (for_remove && plan_count > 0) return $urandom_range(plan_count - 1);
         return $urandom_range(plan_count);
      end
      if (r < 95) return $urandom_range(16);
      return $urandom_range(31);
   endfunction

   task automatic add_random_item(int mode);
      int r;
      logic [2:0] kind;
      r = $urandom_range(99);
      if (r < 2) kind = REQ_UNUSED;
      else if (r < 17) kind = REQ_FIND;
      else if (mode == 0) begin
         if (r < 75) kind = 3'($urandom_range(1) ? REQ_INSERT : $urandom_range(1));
         else kind = 3'($urandom_range(REQ_POP_FRONT, REQ_REMOVE));
      end else if (mode == 1) begin
         if (r < 75) kind = 3'($urandom_range(1) ? REQ_REMOVE : $urandom_range(2, 3));
         else kind = 3'($urandom_range(REQ_PUSH_FRONT, REQ_INSERT));
      end else begin
         kind = 3'($urandom_range(REQ_PUSH_FRONT, REQ_REMOVE));
      end
      add_item(kind, pick_position(kind == REQ_REMOVE), pick_value());
   endtask

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Acceptance of a request transaction: predict its result and move the idle phases along.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         awaited_results.push_back(deque_response(req_data));
         accepted_items++;
         req_taken = 1'b1;
         if (accepted_items == 500) begin
            send_idle_pct = 77;
            recv_idle_pct = 30;
         end else if (accepted_items == 1000) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= queued_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!pressure_done && accepted_items >= 1100) begin
         pressure_done = 1'b1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      idq_rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = awaited_results.pop_front();
            check_field("status", exp_rsp.status, rsp_data.status);
            check_field("found", exp_rsp.found, rsp_data.found);
            check_field("found_index", exp_rsp.found_index, rsp_data.found_index);
            check_field("entry_count", exp_rsp.entry_count, rsp_data.entry_count);
         end
      end
   end

   initial begin
      add_item(REQ_FIND, 0, 32'sd5);
      add_item(REQ_POP_FRONT, 0, 32'sd0);
      add_item(REQ_POP_BACK, 0, 32'sd0);
      add_item(REQ_REMOVE, 0, 32'sd0);
      add_item(REQ_INSERT, 1, 32'sd9);
      add_item(REQ_INSERT, 0, 32'sh8000_0000);
      add_item(REQ_PUSH_FRONT, 0, 32'sh7FFF_FFFF);
      add_item(REQ_PUSH_BACK, 0, -32'sd1);
      add_item(REQ_INSERT, 3, 32'sd0);
      add_item(REQ_INSERT, 1, 32'sd123);
      add_item(REQ_FIND, 0, 32'sd0);
      add_item(REQ_FIND, 0, 32'sd999);
      add_item(REQ_REMOVE, 5, 32'sd0);
      add_item(REQ_REMOVE, 2, 32'sd0);
      add_item(REQ_UNUSED, 31, 32'shFFFF_FFFF);
      while (plan_count < CAPACITY) begin
         add_item(REQ_PUSH_BACK, 0, pick_value());
      end
      add_item(REQ_PUSH_FRONT, 0, 32'sd1);
      add_item(REQ_INSERT, 16, 32'sd2);
      add_item(REQ_INSERT, 17, 32'sd3);
      add_item(REQ_FIND, 0, 32'sh7FFF_FFFF);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         add_random_item((n / 40) % 3);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || req_valid || awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
